@@ rtl/sacl_pkg.sv @@
// Shared types and constants of the set-associative LRU tag directory.
`default_nettype none

package sacl_pkg;

  // Register indexes on the configuration port (byte address / 4).
  localparam logic [1:0] REG_OFFSET_BITS = 2'd0;
  localparam logic [1:0] REG_SET_BITS    = 2'd1;
  localparam logic [1:0] REG_WAYS        = 2'd2;

  localparam int TAG_W  = 32;
  localparam int ADDR_W = 32;

  // Sequencer states, one-hot.
  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_DECODE = 9'b000000100,
    S_READ   = 9'b000001000,
    S_LOAD   = 9'b000010000,
    S_SCAN   = 9'b000100000,
    S_PICK   = 9'b001000000,
    S_AGE    = 9'b010000000,
    S_WRITE  = 9'b100000000
  } sacl_state_t;

  // Per-way status from the shared way unit.
  typedef struct packed {
    logic match;
    logic free;
    logic older;
  } sacl_way_stat_t;

endpackage

`default_nettype wire

@@ rtl/sacl_store.sv @@
// Set metadata memory (valid bits and ages per set) and per-way tag memory.
`default_nettype none

module sacl_store import sacl_pkg::*; #(
  parameter int SETS   = 64,
  parameter int SET_W  = 6,
  parameter int WAY_W  = 3,
  parameter int META_W = 32
) (
  input  wire logic                     clk,
  input  wire logic                     meta_we,
  input  wire logic [SET_W-1:0]         meta_waddr,
  input  wire logic [META_W-1:0]        meta_wdata,
  input  wire logic                     meta_re,
  input  wire logic [SET_W-1:0]         meta_raddr,
  output logic      [META_W-1:0]        meta_rdata,
  input  wire logic                     tag_we,
  input  wire logic [SET_W+WAY_W-1:0]   tag_waddr,
  input  wire logic [TAG_W-1:0]         tag_wdata,
  input  wire logic                     tag_re,
  input  wire logic [SET_W+WAY_W-1:0]   tag_raddr,
  output logic      [TAG_W-1:0]         tag_rdata
);

  localparam int TAG_DEPTH = SETS << WAY_W;

  logic [META_W-1:0] meta_mem [SETS];
  logic [TAG_W-1:0]  tag_mem  [TAG_DEPTH];

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    if (meta_re) begin
      meta_rdata <= meta_mem[meta_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[tag_waddr] <= tag_wdata;
    end
    if (tag_re) begin
      tag_rdata <= tag_mem[tag_raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/sacl_way_unit.sv @@
// Shared per-way unit: tag compare, free/oldest checks and LRU age update.
`default_nettype none

module sacl_way_unit import sacl_pkg::*; #(
  parameter int WAYS  = 8,
  parameter int AGE_W = 3
) (
  input  wire logic             valid_i,
  input  wire logic [AGE_W-1:0] age_i,
  input  wire logic [TAG_W-1:0] tag_i,
  input  wire logic [TAG_W-1:0] tag_ref_i,
  input  wire logic [AGE_W-1:0] oldest_i,
  input  wire logic [AGE_W-1:0] target_i,
  input  wire logic             is_w_i,
  input  wire logic             hit_i,
  output sacl_way_stat_t        stat_o,
  output logic      [AGE_W-1:0] age_nxt_o
);

  localparam logic [AGE_W-1:0] MAX_AGE = AGE_W'(WAYS - 1);

  logic bump;

  always_comb begin
    stat_o.match = valid_i && (tag_i == tag_ref_i);
    stat_o.free  = !valid_i;
    stat_o.older = age_i > oldest_i;

    // Age every other valid way; on a hit only those younger than the hit way.
    bump = !is_w_i && valid_i && (!hit_i || (age_i < target_i));
    if (is_w_i) begin
      age_nxt_o = '0;
    end else if (bump && (age_i < MAX_AGE)) begin
      age_nxt_o = age_i + AGE_W'(1);
    end else begin
      age_nxt_o = age_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/set_assoc_cache_lru_lookup.sv @@
// Top level: set-associative tag directory with true LRU, sequenced over ways.
// Usage
//   Input channel (in_valid/in_ready, in_address): one cache access per
//   transaction. Output channel (out_valid/out_ready): one result per access,
//   giving hit, the way that hit or was filled, whether a valid block was
//   evicted, and the saturating hit count including this access.
//   Configuration (APB style, pready tied high): offset_bits at 0x0,
//   set_index_bits at 0x4, ways_in_use at 0x8; write only while idle.
// Sequence
//   An accepted access passes through decode, metadata read and load, a
//   search of the ways in use with each tag read one way ahead of its
//   compare, an age update of each way in use through the shared way unit,
//   a pick and a write-back. in_ready is high only in idle: one access at a time.
// Reset
//   After rst_n the metadata memory is swept one set per cycle, over all SETS
//   sets, to clear valid bits and ages; no access is taken meanwhile, config is.
// Stall
//   The result sits in an output register; a stalled receiver holds the
//   finished access in its write-back step until the register frees up.
`default_nettype none

module set_assoc_cache_lru_lookup import sacl_pkg::*; #(
  parameter int WAYS      = 8,
  parameter int SETS      = 64,
  parameter int ADDR_BITS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [ADDR_W-1:0] in_address,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_hit,
  output logic      [2:0]        out_way,
  output logic                   out_evicted,
  output logic      [31:0]       out_hits_so_far,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [3:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int AGE_W  = WAY_W;
  localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int MAX_SB = $clog2(SETS + 1) - 1;
  localparam int META_W = WAYS * (1 + AGE_W);
  localparam logic [SET_W-1:0] SET_LAST = SET_W'(SETS - 1);
  localparam logic [63:0] ADDR_MASK64 =
    (ADDR_BITS >= 64) ? {64{1'b1}} : ((64'd1 << ADDR_BITS) - 64'd1);
  localparam logic [ADDR_W-1:0] ADDR_MASK = ADDR_MASK64[ADDR_W-1:0];

  // Configuration registers
  logic [4:0] cfg_off_r;
  logic [2:0] cfg_sbits_r;
  logic [3:0] cfg_ways_r;

  // Sequencer and datapath registers
  sacl_state_t         state_r, state_nxt;
  logic [ADDR_W-1:0]   addr_r;
  logic [SET_W-1:0]    set_r, set_nxt;
  logic [TAG_W-1:0]    tag_r, tag_nxt;
  logic [WAYS-1:0]     valid_r;
  logic [AGE_W-1:0]    age_r [WAYS];
  logic [WAY_W-1:0]    issue_idx_r, issue_idx_nxt;
  logic                issue_done_r, issue_done_nxt;
  logic                cmp_vld_r, cmp_vld_nxt;
  logic [WAY_W-1:0]    cmp_idx_r, cmp_idx_nxt;
  logic                hit_r, hit_nxt;
  logic                free_found_r, free_found_nxt;
  logic [WAY_W-1:0]    free_idx_r, free_idx_nxt;
  logic [AGE_W-1:0]    oldest_age_r, oldest_age_nxt;
  logic [WAY_W-1:0]    oldest_idx_r, oldest_idx_nxt;
  logic [AGE_W-1:0]    target_r, target_nxt;
  logic [WAY_W-1:0]    w_r, w_nxt;
  logic                evicted_r, evicted_nxt;
  logic [WAY_W-1:0]    age_idx_r, age_idx_nxt;
  logic [SET_W-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic [31:0]         hit_cnt_r, hit_cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_hit_r;
  logic [2:0]          out_way_r;
  logic                out_evicted_r;
  logic [31:0]         out_cnt_r;

  // Decode and control
  logic [ADDR_W-1:0]   addr_m, blk;
  logic [2:0]          sbits;
  logic [31:0]         set_mask;
  logic [WAY_W-1:0]    nways_m1;
  logic                slot_free;
  logic                cfg_wr;
  logic                out_load;

  // Memory ports
  logic                meta_we, meta_re;
  logic [SET_W-1:0]    meta_waddr;
  logic [META_W-1:0]   meta_wdata, meta_rdata;
  logic                tag_we, tag_re;
  logic [TAG_W-1:0]    tag_rdata;
  logic [SET_W+WAY_W-1:0] tag_raddr;

  // Shared way unit
  logic [WAY_W-1:0]    unit_idx;
  logic [AGE_W-1:0]    unit_age, unit_age_nxt;
  sacl_way_stat_t      unit_stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (paddr[3:2])
      REG_OFFSET_BITS: prdata = {27'd0, cfg_off_r};
      REG_SET_BITS:    prdata = {29'd0, cfg_sbits_r};
      REG_WAYS:        prdata = {28'd0, cfg_ways_r};
      default:         prdata = '0;
    endcase
  end

  // Cap set bits at what SETS holds, clamp ways in use to 1..WAYS.
  always_comb begin
    sbits = (int'(cfg_sbits_r) > MAX_SB) ? 3'(MAX_SB) : cfg_sbits_r;
    if (cfg_ways_r == 4'd0) begin
      nways_m1 = '0;
    end else if (int'(cfg_ways_r) > WAYS) begin
      nways_m1 = WAY_W'(WAYS - 1);
    end else begin
      nways_m1 = WAY_W'(cfg_ways_r - 4'd1);
    end
    addr_m   = addr_r & ADDR_MASK;
    blk      = addr_m >> cfg_off_r;
    set_mask = (32'd1 << sbits) - 32'd1;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign slot_free = !out_valid_r || out_ready;

  assign unit_idx = (state_r == S_AGE) ? age_idx_r : cmp_idx_r;
  assign unit_age = age_r[unit_idx];

  sacl_way_unit #(
    .WAYS  (WAYS),
    .AGE_W (AGE_W)
  ) u_way (
    .valid_i   (valid_r[unit_idx]),
    .age_i     (unit_age),
    .tag_i     (tag_rdata),
    .tag_ref_i (tag_r),
    .oldest_i  (oldest_age_r),
    .target_i  (target_r),
    .is_w_i    (unit_idx == w_r),
    .hit_i     (hit_r),
    .stat_o    (unit_stat),
    .age_nxt_o (unit_age_nxt)
  );

  // Pack the working row for write-back: the chosen way becomes valid.
  always_comb begin
    meta_wdata = '0;
    if (state_r == S_WRITE) begin
      for (int i = 0; i < WAYS; i++) begin
        meta_wdata[i] = valid_r[i] || (WAY_W'(i) == w_r);
        meta_wdata[WAYS + i*AGE_W +: AGE_W] = age_r[i];
      end
    end
  end

  assign tag_raddr = {set_r, issue_idx_r};

  sacl_store #(
    .SETS   (SETS),
    .SET_W  (SET_W),
    .WAY_W  (WAY_W),
    .META_W (META_W)
  ) u_store (
    .clk        (clk),
    .meta_we    (meta_we),
    .meta_waddr (meta_waddr),
    .meta_wdata (meta_wdata),
    .meta_re    (meta_re),
    .meta_raddr (set_r),
    .meta_rdata (meta_rdata),
    .tag_we     (tag_we),
    .tag_waddr  ({set_r, w_r}),
    .tag_wdata  (tag_r),
    .tag_re     (tag_re),
    .tag_raddr  (tag_raddr),
    .tag_rdata  (tag_rdata)
  );

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    set_nxt        = set_r;
    tag_nxt        = tag_r;
    issue_idx_nxt  = issue_idx_r;
    issue_done_nxt = issue_done_r;
    cmp_vld_nxt    = cmp_vld_r;
    cmp_idx_nxt    = cmp_idx_r;
    hit_nxt        = hit_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    oldest_age_nxt = oldest_age_r;
    oldest_idx_nxt = oldest_idx_r;
    target_nxt     = target_r;
    w_nxt          = w_r;
    evicted_nxt    = evicted_r;
    age_idx_nxt    = age_idx_r;
    clr_cnt_nxt    = clr_cnt_r;
    hit_cnt_nxt    = hit_cnt_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_load       = 1'b0;
    meta_we        = 1'b0;
    meta_waddr     = set_r;
    meta_re        = 1'b0;
    tag_we         = 1'b0;
    tag_re         = 1'b0;

    case (state_r)
      S_CLEAR: begin
        // Sweep the metadata memory: all ways invalid, ages zero.
        meta_we    = 1'b1;
        meta_waddr = clr_cnt_r;
        if (clr_cnt_r == SET_LAST) begin
          state_nxt = S_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + SET_W'(1);
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        set_nxt   = blk[SET_W-1:0] & set_mask[SET_W-1:0];
        tag_nxt   = blk >> sbits;
        state_nxt = S_READ;
      end
      S_READ: begin
        meta_re   = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        issue_idx_nxt  = '0;
        issue_done_nxt = 1'b0;
        cmp_vld_nxt    = 1'b0;
        hit_nxt        = 1'b0;
        free_found_nxt = 1'b0;
        free_idx_nxt   = '0;
        oldest_age_nxt = '0;
        oldest_idx_nxt = '0;
        w_nxt          = '0;
        evicted_nxt    = 1'b0;
        state_nxt      = S_SCAN;
      end
      S_SCAN: begin
        // Issue the tag read one way ahead of the compare.
        if (!issue_done_r) begin
          tag_re = 1'b1;
          if (issue_idx_r == nways_m1) begin
            issue_done_nxt = 1'b1;
          end else begin
            issue_idx_nxt = issue_idx_r + WAY_W'(1);
          end
        end
        cmp_vld_nxt = !issue_done_r;
        cmp_idx_nxt = issue_idx_r;
        if (cmp_vld_r) begin
          // Lowest matching way wins; lowest of equal oldest ages wins.
          if (unit_stat.match && !hit_r) begin
            hit_nxt    = 1'b1;
            w_nxt      = cmp_idx_r;
            target_nxt = unit_age;
          end
          if (unit_stat.free && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = cmp_idx_r;
          end
          if (unit_stat.older) begin
            oldest_age_nxt = unit_age;
            oldest_idx_nxt = cmp_idx_r;
          end
          if (cmp_idx_r == nways_m1) begin
            state_nxt = S_PICK;
          end
        end
      end
      S_PICK: begin
        if (!hit_r) begin
          w_nxt       = free_found_r ? free_idx_r : oldest_idx_r;
          evicted_nxt = !free_found_r;
        end
        age_idx_nxt = '0;
        state_nxt   = S_AGE;
      end
      S_AGE: begin
        if (age_idx_r == nways_m1) begin
          state_nxt = S_WRITE;
        end else begin
          age_idx_nxt = age_idx_r + WAY_W'(1);
        end
      end
      S_WRITE: begin
        // Hold until the output register frees up.
        if (slot_free) begin
          meta_we = 1'b1;
          tag_we  = !hit_r;
          if (hit_r && (hit_cnt_r != 32'hFFFF_FFFF)) begin
            hit_cnt_nxt = hit_cnt_r + 32'd1;
          end
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      hit_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      cfg_off_r   <= 5'd4;
      cfg_sbits_r <= 3'd6;
      cfg_ways_r  <= 4'd8;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      hit_cnt_r   <= hit_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_OFFSET_BITS: cfg_off_r   <= pwdata[4:0];
          REG_SET_BITS:    cfg_sbits_r <= pwdata[2:0];
          REG_WAYS:        cfg_ways_r  <= pwdata[3:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      addr_r <= in_address;
    end
    set_r        <= set_nxt;
    tag_r        <= tag_nxt;
    issue_idx_r  <= issue_idx_nxt;
    issue_done_r <= issue_done_nxt;
    cmp_vld_r    <= cmp_vld_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    hit_r        <= hit_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    oldest_age_r <= oldest_age_nxt;
    oldest_idx_r <= oldest_idx_nxt;
    target_r     <= target_nxt;
    w_r          <= w_nxt;
    evicted_r    <= evicted_nxt;
    age_idx_r    <= age_idx_nxt;
    if (state_r == S_LOAD) begin
      for (int i = 0; i < WAYS; i++) begin
        valid_r[i] <= meta_rdata[i];
        age_r[i]   <= meta_rdata[WAYS + i*AGE_W +: AGE_W];
      end
    end else if (state_r == S_AGE) begin
      age_r[age_idx_r] <= unit_age_nxt;
    end
    if (out_load) begin
      out_hit_r     <= hit_r;
      out_way_r     <= 3'(w_r);
      out_evicted_r <= evicted_r;
      out_cnt_r     <= hit_cnt_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_way         = out_way_r;
  assign out_evicted     = out_evicted_r;
  assign out_hits_so_far = out_cnt_r;

endmodule

`default_nettype wire

@@ tb/set_assoc_cache_lru_lookup_test.sv @@
// Self-checking testbench for the set-associative LRU tag directory.
`timescale 1ns / 1ps

module set_assoc_cache_lru_lookup_test import sacl_pkg::*;;

  localparam int WAYS         = 8;
  localparam int SETS         = 64;
  localparam int MAX_SET_BITS = $clog2(SETS + 1) - 1;

  // One lookup outcome, as the result channel carries it.
  typedef struct packed {
    logic        hit;
    logic [2:0]  way;
    logic        evicted;
    logic [31:0] hits;
  } lookup_result_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [ADDR_W-1:0] in_address;
  logic              out_valid;
  logic              out_ready;
  logic              out_hit;
  logic [2:0]        out_way;
  logic              out_evicted;
  logic [31:0]       out_hits_so_far;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [3:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  // Shadow directory: valid bits, tags and ages per set and way.
  bit             dir_valid [SETS*WAYS];
  bit [31:0]      dir_tag   [SETS*WAYS];
  bit [2:0]       dir_age   [SETS*WAYS];
  bit [31:0]      hit_total;
  bit [4:0]       dir_offset   = 5'd4;
  bit [2:0]       dir_set_bits = 3'd6;
  bit [3:0]       dir_ways     = 4'd8;

  lookup_result_t lookups_due [$];
  lookup_result_t want;
  int             mismatch_count;
  bit             idle_on;
  int             rx_hold;
  int             rx_stall;

  always #6 clk = ~clk;

  set_assoc_cache_lru_lookup #(
    .WAYS      (WAYS),
    .SETS      (SETS),
    .ADDR_BITS (32)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_address      (in_address),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_hit         (out_hit),
    .out_way         (out_way),
    .out_evicted     (out_evicted),
    .out_hits_so_far (out_hits_so_far),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // Set index width actually used: capped at what SETS can hold.
  function automatic int unsigned live_set_bits();
    return (dir_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : dir_set_bits;
  endfunction

  // Compute the outcome of one access and advance the shadow directory.
  task automatic compute_lookup(input logic [31:0] addr, output lookup_result_t res);
    int unsigned sb, nw, base, w, i;
    logic [31:0] blk, tg;
    bit [2:0]    target, oldest;
    bit          hit, found, evicted;
    sb  = live_set_bits();
    nw  = (dir_ways == 0) ? 1 : ((dir_ways > WAYS) ? WAYS : dir_ways);
    blk = addr >> dir_offset;
    tg  = blk >> sb;
    base = (blk & ((32'd1 << sb) - 1)) * WAYS;
    hit = 1'b0;
    found = 1'b0;
    evicted = 1'b0;
    w = 0;
    // Search the ways in use; the lowest matching way wins.
    for (i = 0; i < nw; i++) begin
      if (!hit && dir_valid[base+i] && dir_tag[base+i] == tg) begin
        hit = 1'b1;
        w = i;
      end
    end
    if (hit) begin
      // Age only valid ways younger than the one that hit.
      target = dir_age[base+w];
      for (i = 0; i < nw; i++) begin
        if (i != w && dir_valid[base+i] && dir_age[base+i] < target &&
            dir_age[base+i] < WAYS - 1) begin
          dir_age[base+i]++;
        end
      end
      if (hit_total != 32'hFFFF_FFFF) hit_total++;
    end else begin
      // Fill the first free way, else evict the oldest (lowest on a tie).
      for (i = 0; i < nw; i++) begin
        if (!found && !dir_valid[base+i]) begin
          found = 1'b1;
          w = i;
        end
      end
      if (!found) begin
        oldest = 3'd0;
        w = 0;
        for (i = 0; i < nw; i++) begin
          if (dir_age[base+i] > oldest) begin
            oldest = dir_age[base+i];
            w = i;
          end
        end
        evicted = 1'b1;
      end
      for (i = 0; i < nw; i++) begin
        if (i != w && dir_valid[base+i] && dir_age[base+i] < WAYS - 1) dir_age[base+i]++;
      end
      dir_valid[base+w] = 1'b1;
      dir_tag[base+w]   = tg;
    end
    dir_age[base+w] = 3'd0;
    res.hit     = hit;
    res.way     = w[2:0];
    res.evicted = evicted;
    res.hits    = hit_total;
  endtask

  // Build an address from a tag and a set under the current shape, random offset.
  function automatic logic [31:0] make_address(input logic [31:0] tag, input int unsigned set);
    logic [63:0] a;
    a = ({32'd0, tag} << live_set_bits()) | set;
    a = (a << dir_offset) | ({$urandom, $urandom} & ((64'd1 << dir_offset) - 1));
    return a[31:0];
  endfunction

  // Offer one access; hold valid and address until accepted, then record
  // the expected outcome. Leave valid high so back-to-back offers need no dip.
  task automatic send_access(input logic [31:0] addr);
    lookup_result_t res;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_address <= addr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    compute_lookup(addr, res);
    lookups_due = {lookups_due, res};
    @(negedge clk);
  endtask

  // APB write: setup cycle, then access cycle; upper bits of the data are noise.
  task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_OFFSET_BITS: dir_offset   = value[4:0];
      REG_SET_BITS:    dir_set_bits = value[2:0];
      REG_WAYS:        dir_ways     = value[3:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_cache_shape(input int unsigned offset_bits, input int unsigned set_bits,
                                 input int unsigned ways);
    write_register(REG_OFFSET_BITS, ($urandom & ~32'h1F) | offset_bits);
    write_register(REG_SET_BITS,    ($urandom & ~32'h7)  | set_bits);
    write_register(REG_WAYS,        ($urandom & ~32'hF)  | ways);
  endtask

  // Drop valid and hold off until every expected result has been taken.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (lookups_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Duplicate tags in one set via a shrink to direct mapped, then a tie on age.
  task automatic test_duplicate_tags_and_ties();
    set_cache_shape(0, 0, 2);
    send_access(32'hA5A5_0001);
    send_access(32'h5A5A_0002);
    wait_idle();
    set_cache_shape(0, 0, 1);
    send_access(32'h5A5A_0002);   // misses way 0 only: same tag lands twice
    wait_idle();
    set_cache_shape(0, 0, 2);
    send_access(32'h5A5A_0002);   // both ways match: lowest must hit
    send_access(32'h0000_0003);   // both ages zero: lowest is the victim
  endtask

  // All-zero and all-one addresses under the reset shape, then hits on both.
  task automatic test_address_extremes();
    wait_idle();
    set_cache_shape(4, 6, 8);
    send_access(32'h0000_0000);
    send_access(32'hFFFF_FFFF);
    send_access(32'h0000_000F);
    send_access(32'hFFFF_FFF0);
  endtask

  // Three ways: three fills, an eviction of the oldest, then a hit.
  task automatic test_lru_replacement();
    wait_idle();
    set_cache_shape(4, 6, 3);
    for (int t = 1; t <= 4; t++) send_access(make_address(32'h0000_0100 + t, 5));
    send_access(make_address(32'h0000_0102, 5));
  endtask

  // Set bits above the cap, ways of zero and ways above the maximum.
  task automatic test_register_clamps();
    wait_idle();
    set_cache_shape(0, 7, 0);
    send_access(32'h1234_5600);
    send_access(32'h1234_5640);   // same set, other tag: direct mapped evicts
    wait_idle();
    set_cache_shape(0, 7, 15);
    send_access(32'h1234_5640);
  endtask

  // Stall the receiver for a long stretch while accesses keep coming.
  task automatic test_backpressure();
    wait_idle();
    set_cache_shape(2, 3, 4);
    @(posedge clk);
    rx_hold = 150;
    @(negedge clk);
    repeat (6) send_access(make_address($urandom_range(0, 5), $urandom_range(0, 1)));
    // Pause the sender until every result is back, then resume.
    wait_idle();
    repeat (3) send_access(make_address($urandom_range(0, 5), $urandom_range(0, 1)));
  endtask

  // Phases of reuse-heavy traffic, each under its own shape; some noise.
  task automatic test_random_traffic();
    int unsigned sb, nw, set_a, set_b;
    logic [31:0] tag_base;
    for (int phase = 0; phase < 12; phase++) begin
      wait_idle();
      case (phase)
        0:       set_cache_shape(0, 0, 1);
        1:       set_cache_shape(31, 7, 15);
        2:       set_cache_shape(16, 6, 8);
        3:       set_cache_shape(0, 6, 0);
        4:       set_cache_shape(3, 1, 8);
        default: set_cache_shape($urandom_range(0, 3) == 0 ? $urandom_range(0, 31) :
                                 $urandom_range(0, 8),
                                 $urandom_range(0, 7), $urandom_range(0, 15));
      endcase
      @(posedge clk);
      idle_on = (phase < 10);
      @(negedge clk);
      sb = live_set_bits();
      nw = (dir_ways == 0) ? 1 : ((dir_ways > WAYS) ? WAYS : dir_ways);
      set_a = $urandom_range(0, (1 << sb) - 1);
      set_b = $urandom_range(0, (1 << sb) - 1);
      tag_base = $urandom;
      for (int n = 0; n < 52; n++) begin
        if ($urandom_range(0, 99) < 12) send_access($urandom);
        else send_access(make_address(tag_base + $urandom_range(0, nw + 1),
                                      $urandom_range(0, 1) ? set_a : set_b));
      end
    end
  endtask

  // Receiver: long hold-off on request, else random stall bursts of random length while idle_on is set.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold = rx_hold - 1;
    end else if (rx_stall > 0) begin
      out_ready <= 1'b0;
      rx_stall = rx_stall - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      rx_stall = $urandom_range(0, 3);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic flag_mismatch(input string field, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, exp_v, act_v);
    mismatch_count++;
  endtask

  // Check each result transaction against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (lookups_due.size() == 0) begin
        flag_mismatch("unexpected result, hits", 32'd0, out_hits_so_far);
      end else begin
        want = lookups_due.pop_front();
        if (out_hit !== want.hit)          flag_mismatch("hit", 32'(want.hit), 32'(out_hit));
        if (out_way !== want.way)          flag_mismatch("way", 32'(want.way), 32'(out_way));
        if (out_evicted !== want.evicted)  flag_mismatch("evicted", 32'(want.evicted),
                                                         32'(out_evicted));
        if (out_hits_so_far !== want.hits) flag_mismatch("hits_so_far", want.hits,
                                                         out_hits_so_far);
      end
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_address = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    idle_on    = 1'b1;
    rx_hold    = 0;
    rx_stall   = 0;
    mismatch_count = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // Writes during the clearing sweep are allowed; accesses wait for in_ready.
    test_duplicate_tags_and_ties();
    test_address_extremes();
    test_lru_replacement();
    test_register_clamps();
    test_backpressure();
    test_random_traffic();
    wait_idle();
    repeat (30) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
